[rtl/core/pur_pkg.sv]
// Shared widths and constants for the polyline resampler.
package pur_pkg;

	localparam int COORD_W   = 32;
	localparam int DIFF_W    = 33;
	localparam int PROD_W    = 66;
	localparam int D2_W      = 68;
	localparam int SQ_W      = 72;
	localparam int QACC_W    = 34;
	localparam int SPACING_W = 31;

	localparam logic [SPACING_W-1:0] SPACING_FLOOR = 31'd66;
	localparam logic [SPACING_W-1:0] SPACING_RESET = 31'd655;

endpackage

[rtl/core/pur_mul.sv]
// Shared unsigned multiplier with a registered product.
module pur_mul
	import pur_pkg::*;
(
	input  logic              clk,
	input  logic [DIFF_W-1:0] op_a,
	input  logic [DIFF_W-1:0] op_b,
	output logic [PROD_W-1:0] prod_q
);

	// One product per cycle, registered before use.
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

[rtl/core/pur_div.sv]
// Restoring divider, one quotient bit per cycle, for a coordinate difference over the sample count.
module pur_div
	import pur_pkg::*;
#(
	parameter int DW = 6
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIFF_W-1:0] dividend,
	input  logic [DW-1:0]     divisor,
	output logic              done_q,
	output logic [DIFF_W-1:0] quot_q,
	output logic [DW-1:0]     rem_q
);

	localparam int CW = $clog2(DIFF_W + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] dsr_q;
	logic [DW:0]   trial;
	logic          fits;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		trial = {rem_q, quot_q[DIFF_W-1]};
		fits  = trial >= {1'b0, dsr_q};
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIFF_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient and remainder datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[DIFF_W-2:0], fits};
			rem_q  <= fits ? DW'(trial - {1'b0, dsr_q}) : trial[DW-1:0];
		end
	end

endmodule

[rtl/core/polyline_uniform_resampler.sv]
// Top level of the polyline resampler: stroke sequencer, shared units and output register.
// The first point of a stroke is presented as one transaction on the cycle after it is
// accepted, and the block is ready again on the cycle after that transaction is taken. A later
// point runs one segment (two on the closing point of a closed stroke): squaring of the three
// magnitudes and the spacing on the shared multiplier, a set-up step and a search for the sample
// count n, three divisions on the shared divider, and then one step and one output per sample.
// No new point is accepted until every sample of the current one has been taken.
module polyline_uniform_resampler
	import pur_pkg::*;
#(
	parameter int MAX_SAMPLES = 32
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [SPACING_W-1:0] cfg_wdata,   // sample_spacing
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [95:0]          s_tdata,     // point_x, point_y, point_z
	input  logic                 s_tlast,     // stroke_finish
	input  logic [1:0]           s_tuser,     // stroke_begin, closed_stroke
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [95:0]          m_tdata,     // sample_x, sample_y, sample_z
	output logic                 m_tlast,     // last_of_run
	output logic [0:0]           m_tuser      // count_clamped
);

	localparam int NW = $clog2(MAX_SAMPLES + 1);
	localparam int RW = NW + 2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ_ISSUE, ST_SQ_ACC, ST_SEARCH_INIT, ST_SEARCH,
		ST_DIV_START, ST_DIV_WAIT, ST_STEP, ST_OUT
	} state_t;

	state_t state_q;

	logic [SPACING_W-1:0] spacing_q;
	logic [COORD_W-1:0]   prev_q  [3];
	logic [COORD_W-1:0]   first_q [3];
	logic                 in_stroke_q;
	logic [COORD_W-1:0]   seg_a_q [3];
	logic [COORD_W-1:0]   seg_b_q [3];
	logic                 second_q;
	logic [1:0]           ax_q;
	logic [D2_W-1:0]      d2_q;
	logic [PROD_W-1:0]    s2_q;
	logic [SQ_W-1:0]      sq_q;
	logic [SQ_W-1:0]      t_q;
	logic [NW-1:0]        k_q;
	logic [NW-1:0]        n_q;
	logic [NW-1:0]        i_q;
	logic                 clamp_q;
	logic [QACC_W-1:0]    q0_q  [3];
	logic [RW-1:0]        r0_q  [3];
	logic [QACC_W-1:0]    qacc_q[3];
	logic [RW-1:0]        racc_q[3];
	logic                 div_start_q;
	logic                 out_valid_q;
	logic [COORD_W-1:0]   out_q [3];
	logic                 out_last_q;
	logic                 out_clamp_q;

	logic [COORD_W-1:0]   pin [3];
	logic [DIFF_W-1:0]    diff [3];
	logic [DIFF_W-1:0]    mag  [3];
	logic [SPACING_W-1:0] spacing_eff;
	logic [DIFF_W-1:0]    mul_a;
	logic [PROD_W-1:0]    prod_q;
	logic [DIFF_W-1:0]    div_dividend;
	logic                 div_done;
	logic [DIFF_W-1:0]    div_quot;
	logic [NW-1:0]        div_rem;
	logic                 div_neg;
	logic [QACC_W-1:0]    q0_new;
	logic [RW-1:0]        r0_new;
	logic [RW-1:0]        two_n;
	logic [RW-1:0]        rsum  [3];
	logic [QACC_W-1:0]    qnext [3];
	logic [RW-1:0]        rnext [3];
	logic [NW-1:0]        i_next;
	logic                 in_acc;
	logic                 out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = out_valid_q && m_tready;

	// Segment differences and their magnitudes, one lane per axis.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			pin[a]  = s_tdata[a*COORD_W +: COORD_W];
			diff[a] = {seg_b_q[a][COORD_W-1], seg_b_q[a]} - {seg_a_q[a][COORD_W-1], seg_a_q[a]};
			mag[a]  = diff[a][DIFF_W-1] ? DIFF_W'(0) - diff[a] : diff[a];
		end
		spacing_eff = (spacing_q < SPACING_FLOOR) ? SPACING_FLOOR : spacing_q;
	end

	// Multiplier operand: the three magnitudes, then the spacing, each squared by the multiplier.
	always_comb begin
		case (ax_q)
			2'd0:    mul_a = mag[0];
			2'd1:    mul_a = mag[1];
			2'd2:    mul_a = mag[2];
			default: mul_a = {2'b00, spacing_eff};
		endcase
	end

	pur_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_a),
		.prod_q (prod_q)
	);

	// Divider operand and the turn of its result into a floored quotient.
	always_comb begin
		case (ax_q)
			2'd0:    begin div_dividend = mag[0]; div_neg = diff[0][DIFF_W-1]; end
			2'd1:    begin div_dividend = mag[1]; div_neg = diff[1][DIFF_W-1]; end
			default: begin div_dividend = mag[2]; div_neg = diff[2][DIFF_W-1]; end
		endcase
		if (div_neg && (div_rem != '0)) begin
			q0_new = QACC_W'(0) - ({1'b0, div_quot} + QACC_W'(1));
			r0_new = RW'(n_q) - RW'(div_rem);
		end else if (div_neg) begin
			q0_new = QACC_W'(0) - {1'b0, div_quot};
			r0_new = '0;
		end else begin
			q0_new = {1'b0, div_quot};
			r0_new = RW'(div_rem);
		end
	end

	pur_div #(.DW(NW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dividend),
		.divisor  (n_q),
		.done_q   (div_done),
		.quot_q   (div_quot),
		.rem_q    (div_rem)
	);

	// Next sample per lane: add the whole and fractional steps, carry once.
	always_comb begin
		two_n  = {1'b0, n_q, 1'b0};
		i_next = i_q + 1'b1;
		for (int a = 0; a < 3; a++) begin
			rsum[a] = racc_q[a] + {r0_q[a][RW-2:0], 1'b0};
			if (rsum[a] >= two_n) begin
				rnext[a] = rsum[a] - two_n;
				qnext[a] = qacc_q[a] + q0_q[a] + QACC_W'(1);
			end else begin
				rnext[a] = rsum[a];
				qnext[a] = qacc_q[a] + q0_q[a];
			end
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SPACING_RESET;
		end else if (cfg_wen) begin
			spacing_q <= cfg_wdata;
		end
	end

	// Sequencer, stroke state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_stroke_q <= 1'b0;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
			second_q    <= 1'b0;
			ax_q        <= '0;
			for (int a = 0; a < 3; a++) begin
				prev_q[a]  <= '0;
				first_q[a] <= '0;
			end
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser[0] || !in_stroke_q) begin
							for (int a = 0; a < 3; a++) begin
								out_q[a]   <= pin[a];
								first_q[a] <= pin[a];
								prev_q[a]  <= pin[a];
							end
							out_last_q  <= 1'b1;
							out_clamp_q <= 1'b0;
							out_valid_q <= 1'b1;
							in_stroke_q <= !s_tlast;
							i_q         <= '0;
							n_q         <= '0;
							second_q    <= 1'b0;
							state_q     <= ST_OUT;
						end else begin
							for (int a = 0; a < 3; a++) begin
								seg_a_q[a] <= prev_q[a];
								seg_b_q[a] <= pin[a];
								prev_q[a]  <= pin[a];
							end
							if (s_tlast) begin
								in_stroke_q <= 1'b0;
							end
							second_q <= s_tlast && s_tuser[1];
							ax_q     <= '0;
							d2_q     <= '0;
							state_q  <= ST_SQ_ISSUE;
						end
					end
				end
				ST_SQ_ISSUE: begin
					state_q <= ST_SQ_ACC;
				end
				ST_SQ_ACC: begin
					if (ax_q == 2'd3) begin
						s2_q    <= prod_q;
						state_q <= ST_SEARCH_INIT;
					end else begin
						d2_q    <= d2_q + D2_W'(prod_q);
						ax_q    <= ax_q + 1'b1;
						state_q <= ST_SQ_ISSUE;
					end
				end
				ST_SEARCH_INIT: begin
					sq_q    <= SQ_W'(s2_q);
					t_q     <= SQ_W'(s2_q) + SQ_W'({s2_q, 1'b0});
					k_q     <= NW'(1);
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (sq_q >= SQ_W'(d2_q)) begin
						n_q     <= k_q;
						clamp_q <= 1'b0;
						ax_q    <= '0;
						state_q <= ST_DIV_START;
					end else if (k_q == NW'(MAX_SAMPLES)) begin
						n_q     <= k_q;
						clamp_q <= 1'b1;
						ax_q    <= '0;
						state_q <= ST_DIV_START;
					end else begin
						sq_q <= sq_q + t_q;
						t_q  <= t_q + SQ_W'({s2_q, 1'b0});
						k_q  <= k_q + 1'b1;
					end
				end
				ST_DIV_START: begin
					div_start_q <= 1'b1;
					state_q     <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						q0_q[ax_q]   <= q0_new;
						r0_q[ax_q]   <= r0_new;
						qacc_q[ax_q] <= '0;
						racc_q[ax_q] <= RW'(n_q);
						if (ax_q == 2'd2) begin
							i_q     <= '0;
							state_q <= ST_STEP;
						end else begin
							ax_q    <= ax_q + 1'b1;
							state_q <= ST_DIV_START;
						end
					end
				end
				ST_STEP: begin
					for (int a = 0; a < 3; a++) begin
						qacc_q[a] <= qnext[a];
						racc_q[a] <= rnext[a];
						out_q[a]  <= seg_a_q[a] + qnext[a][COORD_W-1:0];
					end
					i_q         <= i_next;
					out_last_q  <= (i_next == n_q) && !second_q;
					out_clamp_q <= clamp_q;
					out_valid_q <= 1'b1;
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (i_q != n_q) begin
							state_q <= ST_STEP;
						end else if (second_q) begin
							for (int a = 0; a < 3; a++) begin
								seg_a_q[a] <= seg_b_q[a];
								seg_b_q[a] <= first_q[a];
							end
							second_q <= 1'b0;
							ax_q     <= '0;
							d2_q     <= '0;
							state_q  <= ST_SQ_ISSUE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {out_q[2], out_q[1], out_q[0]};
	assign m_tlast    = out_last_q;
	assign m_tuser[0] = out_clamp_q;

endmodule
